[hw/rtl/pic8_pkg.sv]
// Package for the 8-line interrupt controller: transaction payload types,
// command and port codes, control word bit positions and init step codes.
// No dependencies.
package pic8_pkg;

	typedef struct packed {
		logic [1:0] command;
		logic       port_select;
		logic [7:0] write_data;
		logic [2:0] irq_line;
	} pic8_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_valid;
		logic [8:0] vector;
	} pic8_rsp_t;

	// Result of a lowest-set-bit search.
	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} pic8_pri_t;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_ASSERT = 2'd2;
	localparam logic [1:0] CMD_ACK    = 2'd3;

	localparam logic PORT_CMD  = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	localparam int ICW1_IC4_BIT  = 0;
	localparam int ICW1_SNGL_BIT = 1;
	localparam int ICW1_INIT_BIT = 4;
	localparam int OCW2_EOI_BIT  = 5;

	localparam logic [7:0] MASK_RESET = 8'hff;

	localparam logic [1:0] STEP_IDLE  = 2'd0;
	localparam logic [1:0] STEP_ICW2  = 2'd1;
	localparam logic [1:0] STEP_ICW34 = 2'd2;
	localparam logic [1:0] STEP_ICW4  = 2'd3;

endpackage

[hw/rtl/interrupt_controller_8259_lite_top.sv]
// Top level of the simplified 8-line interrupt controller.
// Depends on pic8_pkg and pic8_pri_enc.
// An accepted request transaction waits in the input register, and its result
// is offered from the result register. Throughput: one transaction per cycle
// while rsp_stall does not hold the result register, set by the single input
// register and result register pair around the update logic.
// Reset (arst_n low, asynchronous) empties both registers, clears request,
// service, base and init state, and sets the mask to all ones.
module interrupt_controller_8259_lite_top import pic8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  pic8_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output pic8_rsp_t rsp
);

	// Input register holding the accepted request transaction.
	logic      valid_s1;
	pic8_req_t item_s1;

	// Result register.
	logic      rsp_valid_q;
	pic8_rsp_t rsp_q;

	// Controller state.
	logic [7:0] request_q;
	logic [7:0] service_q;
	logic [7:0] mask_q;
	logic [7:0] base_q;
	logic [1:0] step_q;
	logic       want_icw3_q;
	logic       want_icw4_q;

	// Next-state values computed from the item in the input register.
	logic [7:0] request_n;
	logic [7:0] service_n;
	logic [7:0] mask_n;
	logic [7:0] base_n;
	logic [1:0] step_n;
	logic       want_icw3_n;
	logic       want_icw4_n;
	pic8_rsp_t  rsp_n;

	logic out_free;
	logic advance;

	pic8_pri_t eoi_pri;
	pic8_pri_t ack_pri;

	// The result register can take a new value when it is empty or its
	// current transaction is being taken this cycle. The item in the input
	// register moves forward, and updates the state, exactly then.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// End of interrupt clears the lowest line in service.
	pic8_pri_enc u_eoi_enc (
		.bits (service_q),
		.pri  (eoi_pri)
	);

	// Acknowledge picks the lowest line that is requested, unmasked and not
	// already in service.
	pic8_pri_enc u_ack_enc (
		.bits (request_q & ~service_q & ~mask_q),
		.pri  (ack_pri)
	);

	always_comb begin
		request_n   = request_q;
		service_n   = service_q;
		mask_n      = mask_q;
		base_n      = base_q;
		step_n      = step_q;
		want_icw3_n = want_icw3_q;
		want_icw4_n = want_icw4_q;
		rsp_n       = '0;

		case (item_s1.command)
			CMD_WRITE: begin
				if (item_s1.port_select == PORT_CMD) begin
					// Initialization word one takes precedence over end of interrupt.
					// Any other command byte is ignored.
					if (item_s1.write_data[ICW1_INIT_BIT]) begin
						want_icw3_n = !item_s1.write_data[ICW1_SNGL_BIT];
						want_icw4_n = item_s1.write_data[ICW1_IC4_BIT];
						step_n      = STEP_ICW2;
					end else if (item_s1.write_data[OCW2_EOI_BIT] && eoi_pri.found) begin
						service_n[eoi_pri.idx] = 1'b0;
					end
				end else begin
					// Data port: the init sequence when active, else the mask.
					// The contents of ICW3 and ICW4 are discarded.
					case (step_q)
						STEP_IDLE: begin
							mask_n = item_s1.write_data;
						end
						STEP_ICW2: begin
							base_n = item_s1.write_data;
							step_n = (want_icw3_q || want_icw4_q) ? STEP_ICW34 : STEP_IDLE;
						end
						STEP_ICW34: begin
							step_n = (want_icw3_q && want_icw4_q) ? STEP_ICW4 : STEP_IDLE;
						end
						default: begin
							step_n = STEP_IDLE;
						end
					endcase
				end
			end
			CMD_READ: begin
				if (item_s1.port_select == PORT_DATA) begin
					rsp_n.read_data = mask_q;
				end
			end
			CMD_ASSERT: begin
				request_n[item_s1.irq_line] = 1'b1;
			end
			default: begin
				// Acknowledge; nothing pending leaves the state untouched.
				if (ack_pri.found) begin
					request_n[ack_pri.idx] = 1'b0;
					service_n[ack_pri.idx] = 1'b1;
					rsp_n.irq_valid        = 1'b1;
					rsp_n.vector           = {1'b0, base_q} + {6'b0, ack_pri.idx};
				end
			end
		endcase
	end

	// Input register control: load whenever it is empty or moving forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_n;
		end
	end

	// Controller state commits together with the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_q   <= '0;
			service_q   <= '0;
			mask_q      <= MASK_RESET;
			base_q      <= '0;
			step_q      <= STEP_IDLE;
			want_icw3_q <= 1'b0;
			want_icw4_q <= 1'b0;
		end else if (advance) begin
			request_q   <= request_n;
			service_q   <= service_n;
			mask_q      <= mask_n;
			base_q      <= base_n;
			step_q      <= step_n;
			want_icw3_q <= want_icw3_n;
			want_icw4_q <= want_icw4_n;
		end
	end

endmodule

[hw/rtl/pic8_pri_enc.sv]
// Lowest-set-bit finder over eight interrupt lines.
// Depends on pic8_pkg for the search result type.
module pic8_pri_enc import pic8_pkg::*; (
	input  logic [7:0] bits,
	output pic8_pri_t  pri
);

	always_comb begin
		pri = '0;
		for (int i = 7; i >= 0; i--) begin
			if (bits[i]) begin
				pri.found = 1'b1;
				pri.idx   = 3'(i);
			end
		end
	end

endmodule
